@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker module of the access controller.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CWAC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("cwac assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CWAC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("cwac assertion failed");

`endif

@@ hdl/cwac_pkg.sv @@
// Package of the card whitelist access controller: sizes, codes, payload types
// and the ID normalisation function. No dependencies.
package cwac_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int ID_BYTES    = 7;
	localparam int ID_W        = 56;
	localparam int LEN_W       = 3;
	localparam int HOLD_W      = 16;
	localparam int ENTRY_W     = 7;
	localparam int KEY_W       = ID_W + LEN_W;
	localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int REG_IDX_W   = 3;

	localparam logic [ID_W-1:0]   MASTER_ID_RST   = ID_W'(64'hD3EC_2B28);
	localparam logic [LEN_W-1:0]  MASTER_LEN_RST  = LEN_W'(4);
	localparam logic [ID_W-1:0]   CLEAR_ID_RST    = ID_W'(64'hB2C8_2C1B);
	localparam logic [LEN_W-1:0]  CLEAR_LEN_RST   = LEN_W'(4);
	localparam logic [HOLD_W-1:0] HOLDOFF_RST     = HOLD_W'(3000);

	typedef enum logic [REG_IDX_W-1:0] {
		REG_MASTER_ID     = 3'd0,
		REG_MASTER_ID_LEN = 3'd1,
		REG_CLEAR_ID      = 3'd2,
		REG_CLEAR_ID_LEN  = 3'd3,
		REG_HOLDOFF_TICKS = 3'd4
	} reg_idx_t;

	typedef enum logic [3:0] {
		ACT_TICK      = 4'd0,
		ACT_IGNORED   = 4'd1,
		ACT_ARMED     = 4'd2,
		ACT_CLEARED   = 4'd3,
		ACT_ADDED     = 4'd4,
		ACT_DUPLICATE = 4'd5,
		ACT_FULL      = 4'd6,
		ACT_GRANTED   = 4'd7,
		ACT_DENIED    = 4'd8
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_SCAN,
		ST_FINISH,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic             mode;
		logic [ID_W-1:0]  card_id;
		logic [LEN_W-1:0] card_id_len;
	} req_t;

	typedef struct packed {
		action_t            action;
		logic               open_door;
		logic [ENTRY_W-1:0] entry_count;
	} rsp_t;

	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic [ID_W-1:0]  bytes;
	} key_t;

	typedef struct packed {
		key_t              master_key;
		key_t              clear_key;
		logic [HOLD_W-1:0] holdoff_ticks;
	} cfg_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		key_t             wdata;
		logic             re;
		logic [IDX_W-1:0] raddr;
	} mem_req_t;

	// Canonical ID: length capped at ID_BYTES, bytes above the length cleared.
	function automatic key_t make_key(input logic [ID_W-1:0] bytes,
			input logic [LEN_W-1:0] len);
		logic [LEN_W-1:0] n;
		key_t             k;
		n = (int'(len) > ID_BYTES) ? LEN_W'(ID_BYTES) : len;
		k.len   = n;
		k.bytes = '0;
		for (int i = 0; i < ID_BYTES; i++) begin
			if (i < int'(n)) begin
				k.bytes[i*8 +: 8] = bytes[i*8 +: 8];
			end
		end
		return k;
	endfunction

endpackage

@@ hdl/cwac_ram.sv @@
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
module cwac_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hdl/cwac_ctrl.sv @@
// Sequencer of the access controller: hold-off, add mode, table count and the
// whitelist scan. Depends on cwac_pkg; drives the whitelist RAM through mem_req.
module cwac_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  cwac_pkg::cfg_t    cfg,
	input  logic              req_valid,
	output logic              req_stall,
	input  cwac_pkg::req_t    req,
	output logic              res_valid,
	input  logic              res_take,
	output cwac_pkg::rsp_t    res,
	output cwac_pkg::mem_req_t mem_req,
	input  cwac_pkg::key_t    mem_rdata
);
	import cwac_pkg::*;

	state_t            state_q, nxt_state;
	key_t              key_q, nxt_key;
	logic              mode_q, nxt_mode;
	logic [HOLD_W-1:0] holdoff_q, nxt_holdoff;
	logic              armed_q, nxt_armed;
	logic [CNT_W-1:0]  count_q, nxt_count;
	logic              add_q, nxt_add;
	logic [CNT_W-1:0]  scan_idx_q, nxt_scan_idx;
	logic              found_q, nxt_found;
	logic              rd_vld_s1, nxt_rd_vld;
	rsp_t              res_q, nxt_res;
	logic              issue;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			holdoff_q  <= '0;
			armed_q    <= 1'b0;
			count_q    <= '0;
			rd_vld_s1  <= 1'b0;
		end else begin
			state_q    <= nxt_state;
			holdoff_q  <= nxt_holdoff;
			armed_q    <= nxt_armed;
			count_q    <= nxt_count;
			rd_vld_s1  <= nxt_rd_vld;
		end
	end

	always_ff @(posedge clk) begin
		key_q      <= nxt_key;
		mode_q     <= nxt_mode;
		add_q      <= nxt_add;
		scan_idx_q <= nxt_scan_idx;
		found_q    <= nxt_found;
		res_q      <= nxt_res;
	end

	always_comb begin
		nxt_state    = state_q;
		nxt_key      = key_q;
		nxt_mode     = mode_q;
		nxt_holdoff  = holdoff_q;
		nxt_armed    = armed_q;
		nxt_count    = count_q;
		nxt_add      = add_q;
		nxt_scan_idx = scan_idx_q;
		nxt_found    = found_q;
		nxt_rd_vld   = 1'b0;
		nxt_res      = res_q;
		req_stall    = 1'b1;
		res_valid    = 1'b0;
		issue        = 1'b0;
		mem_req      = '0;
		mem_req.waddr = count_q[IDX_W-1:0];
		mem_req.wdata = key_q;
		mem_req.raddr = scan_idx_q[IDX_W-1:0];

		case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					nxt_key   = make_key(req.card_id, req.card_id_len);
					nxt_mode  = req.mode;
					nxt_state = ST_EVAL;
				end
			end
			ST_EVAL: begin
				nxt_res.open_door = 1'b0;
				nxt_state         = ST_EMIT;
				if (!mode_q) begin
					if (holdoff_q != '0) begin
						nxt_holdoff = holdoff_q - HOLD_W'(1);
					end
					nxt_res.action = ACT_TICK;
				end else if (holdoff_q != '0) begin
					nxt_res.action = ACT_IGNORED;
				end else begin
					nxt_holdoff = cfg.holdoff_ticks;
					// The master test takes priority over the clear test.
					if (key_q == cfg.master_key) begin
						nxt_armed      = 1'b1;
						nxt_res.action = ACT_ARMED;
					end else if (key_q == cfg.clear_key) begin
						nxt_armed      = 1'b0;
						nxt_count      = '0;
						nxt_res.action = ACT_CLEARED;
					end else if (armed_q && count_q >= CNT_W'(MAX_ENTRIES)) begin
						nxt_armed      = 1'b0;
						nxt_res.action = ACT_FULL;
					end else begin
						nxt_add      = armed_q;
						nxt_armed    = 1'b0;
						nxt_scan_idx = '0;
						nxt_found    = 1'b0;
						nxt_state    = ST_SCAN;
					end
				end
				nxt_res.entry_count = ENTRY_W'(nxt_count);
			end
			ST_SCAN: begin
				// One read is issued per cycle; its data is compared in the next cycle.
				issue        = scan_idx_q < count_q;
				mem_req.re   = issue;
				nxt_rd_vld   = issue;
				nxt_scan_idx = scan_idx_q + CNT_W'(issue);
				if (rd_vld_s1 && mem_rdata == key_q) begin
					nxt_found = 1'b1;
				end
				if (!issue && !rd_vld_s1) begin
					nxt_state = ST_FINISH;
				end
			end
			ST_FINISH: begin
				nxt_res.open_door = 1'b0;
				if (add_q) begin
					if (found_q) begin
						nxt_res.action = ACT_DUPLICATE;
					end else begin
						mem_req.we     = 1'b1;
						nxt_count      = count_q + CNT_W'(1);
						nxt_res.action = ACT_ADDED;
					end
				end else if (found_q) begin
					nxt_res.action    = ACT_GRANTED;
					nxt_res.open_door = 1'b1;
				end else begin
					nxt_res.action = ACT_DENIED;
				end
				nxt_res.entry_count = ENTRY_W'(nxt_count);
				nxt_state           = ST_EMIT;
			end
			ST_EMIT: begin
				res_valid = 1'b1;
				if (res_take) begin
					nxt_state = ST_IDLE;
				end
			end
			default: begin
				nxt_state = ST_IDLE;
			end
		endcase
	end

	assign res = res_q;

endmodule

@@ hdl/card_whitelist_access_control.sv @@
// Top level of the card whitelist access controller.
// Depends on cwac_pkg, cwac_ctrl and cwac_ram.
//
// Each request is a tick or a card read and yields exactly one response. Ticks,
// ignored reads, master and clear cards and a full table pass through the EVAL
// and EMIT states to the response register. Any other read goes on from EVAL to
// SCAN, which reads the whitelist through the single read port of the table RAM,
// one entry per cycle, then passes through FINISH and EMIT. The controller
// returns to idle as the response is registered. The response sits in an output
// register, so the next request is accepted while a finished response still
// waits on rsp_stall. Configuration registers must be written with cfg_we,
// cfg_index and cfg_data only while the block is idle; the block itself does not
// enforce this.
module card_whitelist_access_control (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [cwac_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [cwac_pkg::ID_W-1:0]        cfg_data,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  cwac_pkg::req_t                   req,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output cwac_pkg::rsp_t                   rsp
);
	import cwac_pkg::*;

	logic [ID_W-1:0]   master_id_q;
	logic [LEN_W-1:0]  master_len_q;
	logic [ID_W-1:0]   clear_id_q;
	logic [LEN_W-1:0]  clear_len_q;
	logic [HOLD_W-1:0] holdoff_q;
	cfg_t              cfg;
	logic              res_valid;
	logic              res_take;
	rsp_t              res;
	mem_req_t          mem_req;
	logic [KEY_W-1:0]  mem_rdata;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_id_q  <= MASTER_ID_RST;
			master_len_q <= MASTER_LEN_RST;
			clear_id_q   <= CLEAR_ID_RST;
			clear_len_q  <= CLEAR_LEN_RST;
			holdoff_q    <= HOLDOFF_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_MASTER_ID:     master_id_q  <= cfg_data;
				REG_MASTER_ID_LEN: master_len_q <= cfg_data[LEN_W-1:0];
				REG_CLEAR_ID:      clear_id_q   <= cfg_data;
				REG_CLEAR_ID_LEN:  clear_len_q  <= cfg_data[LEN_W-1:0];
				REG_HOLDOFF_TICKS: holdoff_q    <= cfg_data[HOLD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		cfg.master_key    = make_key(master_id_q, master_len_q);
		cfg.clear_key     = make_key(clear_id_q, clear_len_q);
		cfg.holdoff_ticks = holdoff_q;
	end

	cwac_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res),
		.mem_req   (mem_req),
		.mem_rdata (key_t'(mem_rdata))
	);

	cwac_ram #(
		.WIDTH (KEY_W),
		.DEPTH (MAX_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (mem_rdata)
	);

	// The response register takes a new transaction when empty or being drained.
	assign res_take = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

@@ hdl/cwac_checker.sv @@
// Port-level checker of the access controller, bound to the top level.
// Depends on cwac_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cwac_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input cwac_pkg::rsp_t rsp
);
	import cwac_pkg::*;

	`CWAC_ASSERT_IMP(a_open_only_granted, clk, arst_n, rsp_valid && rsp.open_door, rsp.action == ACT_GRANTED)
	`CWAC_ASSERT_IMP(a_granted_opens, clk, arst_n, rsp_valid && rsp.action == ACT_GRANTED, rsp.open_door)
	`CWAC_ASSERT_IMP(a_cleared_empty, clk, arst_n, rsp_valid && rsp.action == ACT_CLEARED, rsp.entry_count == '0)
	`CWAC_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

endmodule

bind card_whitelist_access_control cwac_checker u_cwac_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

@@ tb/sv/tb_card_whitelist_access_control.sv @@
// Self-checking testbench of the card whitelist access controller.
// Depends on cwac_pkg and card_whitelist_access_control; a scoreboard class predicts
// every response from its own copy of the whitelist, the hold-off and the registers.
`timescale 1ns / 1ps

module tb_card_whitelist_access_control;
	import cwac_pkg::*;

	localparam int POOL_SIZE = 96;

	class whitelist_scoreboard;
		logic [ID_W-1:0]   master_id;
		logic [LEN_W-1:0]  master_len;
		logic [ID_W-1:0]   clear_id;
		logic [LEN_W-1:0]  clear_len;
		logic [HOLD_W-1:0] holdoff;
		key_t              listed_ids[MAX_ENTRIES];
		int                n_listed;
		bit                armed;
		int                hold_left;
		rsp_t              due_responses[$];
		int                errors;

		function new();
			master_id  = ID_W'(64'hD3EC_2B28);
			master_len = LEN_W'(4);
			clear_id   = ID_W'(64'hB2C8_2C1B);
			clear_len  = LEN_W'(4);
			holdoff    = HOLD_W'(3000);
			n_listed   = 0;
			armed      = 1'b0;
			hold_left  = 0;
			errors     = 0;
		endfunction

		static function logic [ID_W-1:0] id_mask(input logic [LEN_W-1:0] len);
			int n;
			n = (int'(len) > ID_BYTES) ? ID_BYTES : int'(len);
			if (n >= ID_BYTES)
				return '1;
			return (ID_W'(1) << (8 * n)) - ID_W'(1);
		endfunction

		// An ID is its length together with the bytes below that length.
		function key_t canon_id(input logic [ID_W-1:0] id, input logic [LEN_W-1:0] len);
			key_t k;
			k.len   = (int'(len) > ID_BYTES) ? LEN_W'(ID_BYTES) : len;
			k.bytes = id & id_mask(len);
			return k;
		endfunction

		function bit is_listed(input key_t k);
			for (int i = 0; i < n_listed; i++) begin
				if (listed_ids[i] == k)
					return 1'b1;
			end
			return 1'b0;
		endfunction

		function void apply_register(input logic [REG_IDX_W-1:0] idx,
				input logic [ID_W-1:0] data);
			case (idx)
				REG_MASTER_ID:     master_id  = data;
				REG_MASTER_ID_LEN: master_len = data[LEN_W-1:0];
				REG_CLEAR_ID:      clear_id   = data;
				REG_CLEAR_ID_LEN:  clear_len  = data[LEN_W-1:0];
				REG_HOLDOFF_TICKS: holdoff    = data[HOLD_W-1:0];
				default: ;
			endcase
		endfunction

		// Works out the door response to one accepted request transaction.
		function void predict_door_response(input req_t r);
			rsp_t    e;
			key_t    k;
			action_t act;
			e.open_door = 1'b0;
			if (!r.mode) begin
				if (hold_left > 0)
					hold_left--;
				act = ACT_TICK;
			end else if (hold_left > 0) begin
				act = ACT_IGNORED;
			end else begin
				k = canon_id(r.card_id, r.card_id_len);
				hold_left = int'(holdoff);
				if (k == canon_id(master_id, master_len)) begin
					armed = 1'b1;
					act = ACT_ARMED;
				end else if (k == canon_id(clear_id, clear_len)) begin
					n_listed = 0;
					armed = 1'b0;
					act = ACT_CLEARED;
				end else if (armed) begin
					armed = 1'b0;
					if (n_listed >= MAX_ENTRIES) begin
						act = ACT_FULL;
					end else if (is_listed(k)) begin
						act = ACT_DUPLICATE;
					end else begin
						listed_ids[n_listed] = k;
						n_listed++;
						act = ACT_ADDED;
					end
				end else if (is_listed(k)) begin
					act = ACT_GRANTED;
					e.open_door = 1'b1;
				end else begin
					act = ACT_DENIED;
				end
			end
			e.action = act;
			e.entry_count = ENTRY_W'(n_listed);
			due_responses.push_back(e);
		endfunction

		function void check_response(input rsp_t got);
			rsp_t want;
			if (due_responses.size() == 0) begin
				errors++;
				$error("response with nothing expected: action %0d", got.action);
				return;
			end
			want = due_responses.pop_front();
			if (got.action !== want.action) begin
				errors++;
				$error("action: expected %0d, actual %0d", want.action, got.action);
			end
			if (got.open_door !== want.open_door) begin
				errors++;
				$error("open_door: expected %0d, actual %0d", want.open_door,
					got.open_door);
			end
			if (got.entry_count !== want.entry_count) begin
				errors++;
				$error("entry_count: expected %0d, actual %0d", want.entry_count,
					got.entry_count);
			end
		endfunction

		function int pending();
			return due_responses.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [ID_W-1:0]      cfg_data;
	logic                 req_valid;
	logic                 req_stall;
	req_t                 req;
	logic                 rsp_valid;
	logic                 rsp_stall;
	rsp_t                 rsp;

	whitelist_scoreboard sb;
	logic [ID_W-1:0]     pool_id[POOL_SIZE];
	logic [LEN_W-1:0]    pool_len[POOL_SIZE];
	bit                  calm;
	bit                  long_hold_req;

	card_whitelist_access_control DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #10 clk = ~clk;

	function automatic logic [ID_W-1:0] rand_id();
		return ID_W'({$urandom(), $urandom()});
	endfunction

	function automatic req_t tick_req();
		req_t r;
		r.mode        = 1'b0;
		r.card_id     = rand_id();
		r.card_id_len = LEN_W'($urandom_range(0, 7));
		return r;
	endfunction

	// With junk set, the bytes above the length carry random values.
	function automatic req_t card_req(input logic [ID_W-1:0] id, input logic [LEN_W-1:0] len,
			input bit junk);
		req_t            r;
		logic [ID_W-1:0] m;
		m = whitelist_scoreboard::id_mask(len);
		r.mode        = 1'b1;
		r.card_id_len = len;
		r.card_id     = junk ? ((id & m) | (rand_id() & ~m)) : id;
		return r;
	endfunction

	function automatic req_t pick_item(input int p_tick, input int p_master, input int p_clear,
			input int p_rand);
		int r;
		int k;
		r = $urandom_range(0, 99);
		k = $urandom_range(0, POOL_SIZE - 1);
		if (r < p_tick)
			return tick_req();
		if (r < p_tick + p_master)
			return card_req(sb.master_id, sb.master_len, 1'b1);
		if (r < p_tick + p_master + p_clear)
			return card_req(sb.clear_id, sb.clear_len, 1'b1);
		if (r < p_tick + p_master + p_clear + p_rand)
			return card_req(rand_id(), LEN_W'($urandom_range(0, 7)), 1'b0);
		return card_req(pool_id[k], pool_len[k], 1'b1);
	endfunction

	function automatic int idle_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	task automatic offer_request(input req_t r);
		int g;
		@(negedge clk);
		req       <= r;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (req_stall);
		sb.predict_door_response(r);
		g = idle_gap();
		if (g > 0) begin
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (g - 1) @(negedge clk);
		end
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [ID_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.apply_register(idx, data);
	endtask

	// Writes every register, with junk above the narrow ones, then pokes the
	// indexes past the end of the map, which must change nothing.
	task automatic set_config(input logic [ID_W-1:0] m_id, input logic [LEN_W-1:0] m_len,
			input logic [ID_W-1:0] c_id, input logic [LEN_W-1:0] c_len,
			input logic [HOLD_W-1:0] hold);
		logic [ID_W-1:0] junk;
		junk = rand_id();
		write_reg(REG_MASTER_ID, m_id);
		write_reg(REG_MASTER_ID_LEN, {junk[ID_W-1:LEN_W], m_len});
		write_reg(REG_CLEAR_ID, c_id);
		write_reg(REG_CLEAR_ID_LEN, {junk[ID_W-1:LEN_W], c_len});
		write_reg(REG_HOLDOFF_TICKS, {junk[ID_W-1:HOLD_W], hold});
		for (int k = 1; k <= 3; k++)
			write_reg(REG_IDX_W'(REG_HOLDOFF_TICKS) + REG_IDX_W'(k), rand_id());
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained(input int settle);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic run_phase(input int n, input int p_tick, input int p_master,
			input int p_clear, input int p_rand, input bit squeeze);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) == 0)
				calm = !calm;
			if (squeeze && i == 100)
				long_hold_req = 1'b1;
			offer_request(pick_item(p_tick, p_master, p_clear, p_rand));
		end
		@(negedge clk);
		req_valid <= 1'b0;
		calm = 1'b0;
	endtask

	// Response stall: random short and long holds, plus one long hold on request.
	initial begin
		int left;
		int r;
		left = 0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				left = 400;
			end
			if (left > 0) begin
				rsp_stall <= 1'b1;
				left--;
			end else if (calm) begin
				rsp_stall <= 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					rsp_stall <= 1'b0;
				end else if (r < 92) begin
					rsp_stall <= 1'b1;
					left = $urandom_range(0, 2);
				end else begin
					rsp_stall <= 1'b1;
					left = $urandom_range(4, 30);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_response(rsp);
	end

	initial begin
		#30_000_000;
		$display("[card_whitelist_access_control] ERROR");
		$finish;
	end

	initial begin
		logic [ID_W-1:0] id_m;
		logic [ID_W-1:0] id_c;
		logic [ID_W-1:0] id_a;
		logic [ID_W-1:0] id_b;
		sb            = new();
		clk           = 1'b0;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		req_valid     = 1'b0;
		req           = '0;
		rsp_stall     = 1'b0;
		calm          = 1'b0;
		long_hold_req = 1'b0;
		for (int i = 0; i < POOL_SIZE; i++) begin
			pool_id[i]  = rand_id();
			pool_len[i] = (i == 0) ? LEN_W'(0) : LEN_W'($urandom_range(1, 7));
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Registers at their reset values: the master card starts the long hold-off.
		offer_request(tick_req());
		offer_request(card_req(sb.master_id, sb.master_len, 1'b1));
		offer_request(card_req(sb.clear_id, sb.clear_len, 1'b1));
		offer_request(tick_req());
		offer_request(card_req(rand_id(), LEN_W'(4), 1'b0));
		@(negedge clk);
		req_valid <= 1'b0;
		wait_drained(8);

		id_m = rand_id();
		id_c = rand_id();
		id_a = rand_id();
		id_b = '1;
		set_config(id_m, LEN_W'(7), id_c, LEN_W'(3), '0);
		offer_request(card_req(id_a, LEN_W'(5), 1'b0));
		offer_request(card_req(id_m, LEN_W'(7), 1'b0));
		offer_request(card_req(id_a, LEN_W'(5), 1'b0));
		offer_request(card_req(id_m, LEN_W'(7), 1'b0));
		offer_request(card_req(id_a, LEN_W'(5), 1'b1));
		offer_request(card_req(id_a, LEN_W'(5), 1'b1));
		offer_request(card_req(id_a, LEN_W'(4), 1'b0));
		offer_request(card_req(id_m, LEN_W'(7), 1'b0));
		offer_request(card_req(id_m, LEN_W'(7), 1'b0));
		// The clear card while armed empties the list and disarms.
		offer_request(card_req(id_c, LEN_W'(3), 1'b1));
		offer_request(card_req(id_a, LEN_W'(5), 1'b0));
		offer_request(card_req(id_m, LEN_W'(7), 1'b0));
		offer_request(card_req(rand_id(), LEN_W'(0), 1'b0));
		offer_request(card_req(rand_id(), LEN_W'(0), 1'b0));
		offer_request(card_req(id_m, LEN_W'(7), 1'b0));
		offer_request(card_req(id_b, LEN_W'(7), 1'b0));
		offer_request(card_req(id_b, LEN_W'(7), 1'b0));
		offer_request(card_req('0, LEN_W'(7), 1'b0));
		offer_request(tick_req());
		@(negedge clk);
		req_valid <= 1'b0;
		wait_drained(8);

		// Master and clear cards identical: the master meaning wins.
		set_config(id_a, LEN_W'(2), id_a, LEN_W'(2), '0);
		offer_request(card_req(id_a, LEN_W'(2), 1'b1));
		offer_request(card_req(id_b, LEN_W'(6), 1'b1));
		offer_request(card_req(id_m, LEN_W'(7), 1'b0));
		@(negedge clk);
		req_valid <= 1'b0;
		wait_drained(8);

		// No clear cards, so the whitelist fills up and reports full.
		set_config(rand_id(), LEN_W'(7), rand_id(), LEN_W'(3), '0);
		run_phase(650, 15, 35, 0, 15, 1'b1);
		wait_drained(8);
		set_config(rand_id(), LEN_W'(0), '1, LEN_W'(7), HOLD_W'(2));
		run_phase(450, 45, 15, 3, 12, 1'b0);
		wait_drained(8);
		id_a = rand_id();
		set_config(id_a, LEN_W'(5), id_a, LEN_W'(5), HOLD_W'(1));
		run_phase(350, 35, 20, 5, 15, 1'b0);
		wait_drained(8);
		set_config('0, LEN_W'(7), rand_id(), LEN_W'(1), '0);
		run_phase(400, 15, 25, 3, 15, 1'b0);
		wait_drained(8);
		// The longest hold-off goes last, since it never runs out.
		set_config('0, LEN_W'(1), '1, LEN_W'(7), '1);
		run_phase(60, 40, 20, 5, 15, 1'b0);
		wait_drained(80);

		if (sb.errors == 0 && sb.pending() == 0)
			$display("[card_whitelist_access_control] OK");
		else
			$display("[card_whitelist_access_control] ERROR");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/cwac_pkg.sv
hdl/cwac_ram.sv
hdl/cwac_ctrl.sv
hdl/card_whitelist_access_control.sv
hdl/cwac_checker.sv
tb/sv/tb_card_whitelist_access_control.sv
